// ===== sv/sttw_pkg.sv =====
// shuffled torus table walker: shared types, codes and constants
// no dependencies; used by shuffled_torus_table_walker_unit
`timescale 1ns / 1ps
package sttw_pkg;

	// request operation codes
	localparam logic [1:0] OP_BUILD = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_STEP  = 2'd2;

	// register map (index bit of the byte address)
	localparam logic REG_SEED = 1'b0;

	localparam logic [31:0] FNV_BASIS  = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME  = 32'd16777619;
	localparam logic [31:0] SEED_RESET = 32'd144000;

	// sequencer states
	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_SH_RNG,
		ST_SH_DIV,
		ST_SH_RI,
		ST_SH_RJ,
		ST_SH_WI,
		ST_SH_WJ,
		ST_F_RD,
		ST_F_R,
		ST_F_G,
		ST_F_B,
		ST_F_E,
		ST_W_RD,
		ST_W_FOLD,
		ST_RESULT
	} state_t;

	// one xorshift32 step
	function automatic logic [31:0] xs_next(input logic [31:0] v);
		logic [31:0] t;
		t = v ^ (v << 13);
		t = t ^ (t >> 17);
		t = t ^ (t << 5);
		return t;
	endfunction

endpackage

// ===== sv/shuffled_torus_table_walker_unit.sv =====
// shuffled torus table walker: top level with cell and permutation memories
// depends on sttw_pkg
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  in      | input     | in_valid/in_stall  | op, digit
//  out     | output    | out_valid/out_stall| pos_x..z, page_number, present, rgb, energy,
//          |           |                    | walk_hash
//  cfg     | input     | apb (psel..pready) | seed at byte address 0
//
// a walk step does one memory read, then eight byte folds of the hash with one
// multiply by the fnv prime per fold, then the result load
// a start or an unused code goes from idle straight to the result load
// a build clears all NCELLS cells, then does NCELLS-1 shuffle swaps (a draw, a
// bit-serial remainder of it, two reads and two writes), then fills FILL cells
// after reset a clearing pass over all NCELLS cells runs before the first request is taken
// a request is taken while an earlier result still waits behind out_stall
`timescale 1ns / 1ps
module shuffled_torus_table_walker_unit #(
	parameter int EDGE   = 10,
	parameter int FILLED = 240
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [3:0]  digit,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  pos_x,
	output logic [3:0]  pos_y,
	output logic [3:0]  pos_z,
	output logic [9:0]  page_number,
	output logic        present,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [15:0] energy,
	output logic [31:0] walk_hash,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int NCELLS = EDGE * EDGE * EDGE;
	localparam int IW     = $clog2(NCELLS);
	localparam int FILL   = (FILLED > NCELLS) ? NCELLS : FILLED;
	localparam int CW     = 51;
	localparam logic [8:0] E1 = 9'(EDGE);
	localparam logic [8:0] E2 = 9'(EDGE * 2);
	localparam logic [8:0] E4 = 9'(EDGE * 4);
	localparam logic [8:0] E8 = 9'(EDGE * 8);

	sttw_pkg::state_t state_q, state_d;

	logic [31:0]   seed_q;
	logic [31:0]   prng_q;
	logic [31:0]   hash_q;
	logic [3:0]    cur_x_q, cur_y_q, cur_z_q;
	logic [1:0]    phase_q;
	logic          build_q;
	logic [IW-1:0] cnt_q;
	logic [IW-1:0] i_q;
	logic [IW-1:0] n_q;
	logic [IW-1:0] c_q;
	logic [IW-1:0] pi_q;
	logic [31:0]   div_q;
	logic [IW:0]   rem_q;
	logic [4:0]    bit_q;
	logic [2:0]    fold_q;
	logic [7:0]    r_q, g_q, b_q;
	logic [3:0]    digit_q;

	// memories
	logic [CW-1:0] cell_mem [NCELLS];
	logic [IW-1:0] perm_mem [NCELLS];
	logic [CW-1:0] cell_rd;
	logic [IW-1:0] perm_rd;
	logic          cell_we, perm_we;
	logic [IW-1:0] cell_wa, cell_ra, perm_wa, perm_ra;
	logic [CW-1:0] cell_wd;
	logic [IW-1:0] perm_wd;

	// result and output registers
	logic [3:0]  res_x_q, res_y_q, res_z_q;
	logic [9:0]  res_page_q;
	logic        res_pres_q;
	logic [23:0] res_col_q;
	logic [15:0] res_en_q;
	logic [31:0] res_hash_q;
	logic        out_valid_q;

	logic        in_take;
	logic        out_free;
	logic [31:0] rnd;
	logic [IW-1:0] idx;
	logic [IW+1:0] rsh, dv;
	logic [IW:0]   rem_d;
	logic [31:0] fold_word, hash_next;
	logic [7:0]  fold_byte;
	logic [8:0]  mv;
	logic [3:0]  moved;
	logic [15:0] page_w;
	logic [15:0] idx_w;
	logic        cfg_wr;

	assign in_take  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign rnd      = sttw_pkg::xs_next(prng_q);
	assign page_w   = 16'(n_q) + 16'd1;

	// apb register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == sttw_pkg::REG_SEED);
	assign prdata = (paddr[2] == sttw_pkg::REG_SEED) ? seed_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= sttw_pkg::SEED_RESET;
		end else if (cfg_wr) begin
			seed_q <= pwdata;
		end
	end

	// linear cell index of the walker
	assign idx_w = ((16'(cur_x_q) * 16'(EDGE)) + 16'(cur_y_q)) * 16'(EDGE) + 16'(cur_z_q);
	assign idx   = idx_w[IW-1:0];

	// bit-serial remainder step
	assign rsh   = {rem_q, div_q[31]};
	assign dv    = (IW+2)'(i_q) + (IW+2)'(1);
	assign rem_d = (rsh >= dv) ? (IW+1)'(rsh - dv) : (IW+1)'(rsh);

	// fnv-1a byte fold: index word first, then page word
	assign fold_word = fold_q[2] ? {22'd0, cell_rd[50:41]} : {16'd0, idx_w};
	always_comb begin
		case (fold_q[1:0])
			2'd0:    fold_byte = fold_word[7:0];
			2'd1:    fold_byte = fold_word[15:8];
			2'd2:    fold_byte = fold_word[23:16];
			default: fold_byte = fold_word[31:24];
		endcase
	end
	assign hash_next = (hash_q ^ {24'd0, fold_byte}) * sttw_pkg::FNV_PRIME;

	// cyclic move: sum stays below 16 * EDGE, so four conditional subtracts
	always_comb begin
		mv = 9'(cur_x_q) + 9'(digit_q);
		case (phase_q)
			2'd0:    mv = 9'(cur_x_q) + 9'(digit_q);
			2'd1:    mv = 9'(cur_y_q) + 9'(digit_q);
			default: mv = 9'(cur_z_q) + 9'(digit_q);
		endcase
		if (mv >= E8) mv = mv - E8;
		if (mv >= E4) mv = mv - E4;
		if (mv >= E2) mv = mv - E2;
		if (mv >= E1) mv = mv - E1;
		moved = mv[3:0];
	end

	// next state and memory controls
	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		cell_we  = 1'b0;
		cell_wa  = cnt_q;
		cell_wd  = '0;
		cell_ra  = idx;
		perm_we  = 1'b0;
		perm_wa  = cnt_q;
		perm_wd  = cnt_q;
		perm_ra  = i_q;
		case (state_q)
			sttw_pkg::ST_CLR: begin
				cell_we = 1'b1;
				perm_we = 1'b1;
				if (cnt_q == IW'(NCELLS - 1)) begin
					state_d = build_q ? sttw_pkg::ST_SH_RNG : sttw_pkg::ST_IDLE;
				end
			end
			sttw_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					case (op)
						sttw_pkg::OP_BUILD: state_d = sttw_pkg::ST_CLR;
						sttw_pkg::OP_STEP:  state_d = sttw_pkg::ST_W_RD;
						default:            state_d = sttw_pkg::ST_RESULT;
					endcase
				end
			end
			sttw_pkg::ST_SH_RNG: state_d = sttw_pkg::ST_SH_DIV;
			sttw_pkg::ST_SH_DIV: begin
				if (bit_q == 5'd31) state_d = sttw_pkg::ST_SH_RI;
			end
			sttw_pkg::ST_SH_RI: begin
				perm_ra = i_q;
				state_d = sttw_pkg::ST_SH_RJ;
			end
			sttw_pkg::ST_SH_RJ: begin
				perm_ra = rem_q[IW-1:0];
				state_d = sttw_pkg::ST_SH_WI;
			end
			sttw_pkg::ST_SH_WI: begin
				perm_we = 1'b1;
				perm_wa = i_q;
				perm_wd = perm_rd;
				state_d = sttw_pkg::ST_SH_WJ;
			end
			sttw_pkg::ST_SH_WJ: begin
				perm_we = 1'b1;
				perm_wa = rem_q[IW-1:0];
				perm_wd = pi_q;
				state_d = (i_q == IW'(1)) ? sttw_pkg::ST_F_RD : sttw_pkg::ST_SH_RNG;
			end
			sttw_pkg::ST_F_RD: begin
				perm_ra = n_q;
				state_d = sttw_pkg::ST_F_R;
			end
			sttw_pkg::ST_F_R: state_d = sttw_pkg::ST_F_G;
			sttw_pkg::ST_F_G: state_d = sttw_pkg::ST_F_B;
			sttw_pkg::ST_F_B: state_d = sttw_pkg::ST_F_E;
			sttw_pkg::ST_F_E: begin
				cell_we = 1'b1;
				cell_wa = c_q;
				cell_wd = {page_w[9:0], 1'b1, b_q, g_q, r_q, rnd[15:0]};
				state_d = (n_q == IW'(FILL - 1)) ? sttw_pkg::ST_RESULT : sttw_pkg::ST_F_RD;
			end
			sttw_pkg::ST_W_RD: begin
				cell_ra = idx;
				state_d = sttw_pkg::ST_W_FOLD;
			end
			sttw_pkg::ST_W_FOLD: begin
				if (fold_q == 3'd7) state_d = sttw_pkg::ST_RESULT;
			end
			sttw_pkg::ST_RESULT: begin
				if (out_free) state_d = sttw_pkg::ST_IDLE;
			end
			default: state_d = sttw_pkg::ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sttw_pkg::ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	// memory ports
	always_ff @(posedge clk) begin
		if (cell_we) cell_mem[cell_wa] <= cell_wd;
		cell_rd <= cell_mem[cell_ra];
	end

	always_ff @(posedge clk) begin
		if (perm_we) perm_mem[perm_wa] <= perm_wd;
		perm_rd <= perm_mem[perm_ra];
	end

	// sequencer datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prng_q  <= 32'd1;
			hash_q  <= sttw_pkg::FNV_BASIS;
			cur_x_q <= '0;
			cur_y_q <= '0;
			cur_z_q <= '0;
			phase_q <= '0;
			build_q <= 1'b0;
			cnt_q   <= '0;
			i_q     <= '0;
			n_q     <= '0;
			bit_q   <= '0;
			fold_q  <= '0;
		end else begin
			case (state_q)
				sttw_pkg::ST_CLR: begin
					cnt_q <= cnt_q + IW'(1);
					i_q   <= IW'(NCELLS - 1);
				end
				sttw_pkg::ST_IDLE: begin
					if (in_take) begin
						cnt_q <= '0;
						n_q   <= '0;
						fold_q <= '0;
						if (op == sttw_pkg::OP_BUILD) begin
							build_q <= 1'b1;
							prng_q  <= (seed_q == 32'd0) ? 32'd1 : seed_q;
						end else if (op == sttw_pkg::OP_START) begin
							cur_x_q <= '0;
							cur_y_q <= '0;
							cur_z_q <= '0;
							phase_q <= '0;
							hash_q  <= sttw_pkg::FNV_BASIS;
						end
					end
				end
				sttw_pkg::ST_SH_RNG: begin
					prng_q <= rnd;
					bit_q  <= '0;
				end
				sttw_pkg::ST_SH_DIV: begin
					bit_q <= bit_q + 5'd1;
				end
				sttw_pkg::ST_SH_WJ: begin
					i_q <= i_q - IW'(1);
				end
				sttw_pkg::ST_F_R, sttw_pkg::ST_F_G, sttw_pkg::ST_F_B: begin
					prng_q <= rnd;
				end
				sttw_pkg::ST_F_E: begin
					prng_q <= rnd;
					n_q    <= n_q + IW'(1);
					if (n_q == IW'(FILL - 1)) build_q <= 1'b0;
				end
				sttw_pkg::ST_W_FOLD: begin
					hash_q <= hash_next;
					fold_q <= fold_q + 3'd1;
					if (fold_q == 3'd7) begin
						if (digit_q != 4'd0) begin
							case (phase_q)
								2'd0:    cur_x_q <= moved;
								2'd1:    cur_y_q <= moved;
								default: cur_z_q <= moved;
							endcase
						end
						phase_q <= (phase_q >= 2'd2) ? 2'd0 : phase_q + 2'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload working registers
	always_ff @(posedge clk) begin
		if (in_take) digit_q <= digit;
		if (state_q == sttw_pkg::ST_SH_RNG) begin
			div_q <= rnd;
			rem_q <= '0;
		end
		if (state_q == sttw_pkg::ST_SH_DIV) begin
			div_q <= {div_q[30:0], 1'b0};
			rem_q <= rem_d;
		end
		if (state_q == sttw_pkg::ST_SH_RJ) pi_q <= perm_rd;
		if (state_q == sttw_pkg::ST_F_R) begin
			c_q <= perm_rd;
			r_q <= rnd[7:0];
		end
		if (state_q == sttw_pkg::ST_F_G) g_q <= rnd[7:0];
		if (state_q == sttw_pkg::ST_F_B) b_q <= rnd[7:0];
	end

	// result assembly
	always_ff @(posedge clk) begin
		if (in_take) begin
			res_x_q    <= '0;
			res_y_q    <= '0;
			res_z_q    <= '0;
			res_page_q <= '0;
			res_pres_q <= 1'b0;
			res_col_q  <= '0;
			res_en_q   <= '0;
			res_hash_q <= (op == sttw_pkg::OP_START) ? sttw_pkg::FNV_BASIS : 32'd0;
		end else if (state_q == sttw_pkg::ST_W_FOLD && fold_q == 3'd7) begin
			res_x_q    <= cur_x_q;
			res_y_q    <= cur_y_q;
			res_z_q    <= cur_z_q;
			res_page_q <= cell_rd[50:41];
			res_pres_q <= cell_rd[40];
			res_col_q  <= cell_rd[39:16];
			res_en_q   <= cell_rd[15:0];
			res_hash_q <= hash_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == sttw_pkg::ST_RESULT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == sttw_pkg::ST_RESULT && out_free) begin
			pos_x       <= res_x_q;
			pos_y       <= res_y_q;
			pos_z       <= res_z_q;
			page_number <= res_page_q;
			present     <= res_pres_q;
			red         <= res_col_q[7:0];
			green       <= res_col_q[15:8];
			blue        <= res_col_q[23:16];
			energy      <= res_en_q;
			walk_hash   <= res_hash_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== verif/shuffled_torus_table_walker_unit_test.sv =====
// testbench for shuffled_torus_table_walker_unit: drives build, start and walk requests,
// predicts every result with its own cube model and checks all fields in order
// depends on sttw_pkg and shuffled_torus_table_walker_unit
`timescale 1ns / 1ps
module shuffled_torus_table_walker_unit_test;

	localparam int EDGE  = 10;
	localparam int CELLS = EDGE * EDGE * EDGE;
	localparam int FILL  = 240;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [2:0] ADDR_SEED = 3'd0;

	typedef struct packed {
		logic [3:0]  x;
		logic [3:0]  y;
		logic [3:0]  z;
		logic [9:0]  page;
		logic        present;
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
		logic [15:0] en;
		logic [31:0] hash;
	} visit_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [1:0] op;
	logic [3:0] digit;
	logic [3:0] pos_x, pos_y, pos_z;
	logic [9:0] page_number;
	logic present;
	logic [7:0] red, green, blue;
	logic [15:0] energy;
	logic [31:0] walk_hash;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;

	// cube model state
	logic [9:0]  cell_page[CELLS];
	logic        cell_full[CELLS];
	logic [23:0] cell_rgb[CELLS];
	logic [15:0] cell_energy[CELLS];
	logic [9:0]  order[CELLS];
	logic [31:0] rng, cur_seed, walk_acc;
	logic [3:0]  wx, wy, wz;
	int          axis;

	visit_t pending_visits[$];
	int     failures = 0;
	int     mismatches = 0;
	bit     hold_req = 0;

	shuffled_torus_table_walker_unit i_dut (.*);

	always #1 clk = ~clk;

	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// xorshift32
	function automatic logic [31:0] draw();
		rng = rng ^ (rng << 13);
		rng = rng ^ (rng >> 17);
		rng = rng ^ (rng << 5);
		return rng;
	endfunction

	function automatic logic [31:0] fnv_word(logic [31:0] h, logic [31:0] v);
		for (int b = 0; b < 4; b++) begin
			h = h ^ ((v >> (8 * b)) & 32'hff);
			h = h * sttw_pkg::FNV_PRIME;
		end
		return h;
	endfunction

	// clear, shuffle and fill the cube from the current seed
	function automatic void rebuild_cube();
		logic [31:0] j;
		logic [9:0]  t;
		logic [7:0]  r, g, b;
		rng = (cur_seed == 0) ? 32'd1 : cur_seed;
		for (int i = 0; i < CELLS; i++) begin
			order[i] = 10'(i);
			cell_page[i] = '0;
			cell_full[i] = 1'b0;
			cell_rgb[i] = '0;
			cell_energy[i] = '0;
		end
		for (int i = CELLS - 1; i > 0; i--) begin
			j = draw() % (i + 1);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		for (int n = 0; n < ((FILL > CELLS) ? CELLS : FILL); n++) begin
			cell_full[order[n]] = 1'b1;
			cell_page[order[n]] = 10'(n + 1);
			r = 8'(draw());
			g = 8'(draw());
			b = 8'(draw());
			cell_rgb[order[n]] = {b, g, r};
			cell_energy[order[n]] = 16'(draw());
		end
	endfunction

	// expected result of one request, advancing the model
	function automatic visit_t predict_visit(logic [1:0] code, logic [3:0] amount);
		visit_t v;
		int idx;
		v = '0;
		case (code)
			sttw_pkg::OP_BUILD: rebuild_cube();
			sttw_pkg::OP_START: begin
				wx = 0; wy = 0; wz = 0; axis = 0;
				walk_acc = sttw_pkg::FNV_BASIS;
				v.hash = walk_acc;
			end
			sttw_pkg::OP_STEP: begin
				idx = (wx * EDGE + wy) * EDGE + wz;
				if (idx >= CELLS) idx = 0;
				walk_acc = fnv_word(walk_acc, 32'(idx));
				walk_acc = fnv_word(walk_acc, {22'd0, cell_page[idx]});
				v.x = wx; v.y = wy; v.z = wz;
				v.page = cell_page[idx];
				v.present = cell_full[idx];
				{v.b, v.g, v.r} = cell_rgb[idx];
				v.en = cell_energy[idx];
				v.hash = walk_acc;
				if (amount != 0) begin
					if (axis == 0) wx = 4'((wx + amount) % EDGE);
					else if (axis == 1) wy = 4'((wy + amount) % EDGE);
					else wz = 4'((wz + amount) % EDGE);
				end
				axis = (axis >= 2) ? 0 : axis + 1;
			end
			default: ;
		endcase
		return v;
	endfunction

	// offer one request and hold it until taken
	task automatic send_request(logic [1:0] code, logic [3:0] amount);
		in_valid <= 1'b1;
		op <= code;
		digit <= amount;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_visits.push_back(predict_visit(code, amount));
	endtask

	task automatic pause_sender(int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		pause_sender(1);
		while (pending_visits.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// apb write, only while drained
	task automatic write_seed(logic [31:0] value);
		wait_drained();
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= ADDR_SEED; pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		cur_seed = value;
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			failures++;
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch %s: expected %h got %h", name, want, got);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		visit_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_visits.size() == 0) begin
				failures++;
				if (mismatches++ < 10) $display("result with no request pending");
			end else begin
				w = pending_visits.pop_front();
				check_field("pos_x", 32'(w.x), 32'(pos_x));
				check_field("pos_y", 32'(w.y), 32'(pos_y));
				check_field("pos_z", 32'(w.z), 32'(pos_z));
				check_field("page_number", 32'(w.page), 32'(page_number));
				check_field("present", 32'(w.present), 32'(present));
				check_field("red", 32'(w.r), 32'(red));
				check_field("green", 32'(w.g), 32'(green));
				check_field("blue", 32'(w.b), 32'(blue));
				check_field("energy", 32'(w.en), 32'(energy));
				check_field("walk_hash", w.hash, walk_hash);
			end
		end
	end

	// receiver stall pattern, with a long hold-off on request
	always begin
		int cyc;
		int mode;
		@(posedge clk);
		if (hold_req) begin
			out_stall <= 1'b1;
			repeat (400) @(posedge clk);
			hold_req = 0;
		end else begin
			cyc++;
			if (cyc % 64 == 0) mode = $urandom_range(0, 2);
			out_stall <= (mode == 0) ? 1'b0 :
				(mode == 1) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 4) != 0);
		end
	end

	// walks before any start, pauses, large digits, unused code, builds at extreme seeds
	task automatic test_directed();
		send_request(sttw_pkg::OP_STEP, 4'd0);
		send_request(sttw_pkg::OP_STEP, 4'd15);
		send_request(sttw_pkg::OP_START, 4'd0);
		send_request(OP_UNUSED, 4'd9);
		send_request(sttw_pkg::OP_BUILD, 4'd0);
		send_request(sttw_pkg::OP_START, 4'd15);
		for (int i = 0; i < 8; i++) send_request(sttw_pkg::OP_STEP, 4'(i * 2 + 1));
		write_seed(32'd0);
		send_request(sttw_pkg::OP_BUILD, 4'd5);
		send_request(sttw_pkg::OP_START, 4'd0);
		send_request(sttw_pkg::OP_STEP, 4'd9);
		send_request(sttw_pkg::OP_STEP, 4'd10);
		send_request(sttw_pkg::OP_STEP, 4'd0);
		write_seed(32'hffff_ffff);
		send_request(sttw_pkg::OP_BUILD, 4'd0);
		send_request(sttw_pkg::OP_STEP, 4'd3);
		send_request(sttw_pkg::OP_START, 4'd0);
		send_request(sttw_pkg::OP_STEP, 4'd12);
	endtask

	// reseed, build, then bursts of walks with occasional restarts and noise
	task automatic test_random_walks(int phases, int per_phase);
		int burst;
		int pick;
		for (int p = 0; p < phases; p++) begin
			write_seed($urandom());
			send_request(sttw_pkg::OP_BUILD, 4'($urandom_range(0, 15)));
			burst = 0;
			for (int i = 0; i < per_phase; i++) begin
				if (burst == 0) begin
					pause_sender($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20));
					burst = $urandom_range(1, 30);
				end
				burst--;
				pick = $urandom_range(0, 99);
				if (pick < 6) send_request(sttw_pkg::OP_START, 4'($urandom_range(0, 15)));
				else if (pick < 8) send_request(OP_UNUSED, 4'($urandom_range(0, 15)));
				else send_request(sttw_pkg::OP_STEP, 4'($urandom_range(0, 15)));
			end
		end
	endtask

	// receiver holds off while the sender keeps offering walk steps
	task automatic test_backpressure();
		hold_req = 1;
		send_request(sttw_pkg::OP_START, 4'd0);
		for (int i = 0; i < 60; i++)
			send_request(sttw_pkg::OP_STEP, 4'($urandom_range(0, 15)));
		wait_drained();
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0; op <= sttw_pkg::OP_BUILD; digit <= '0; out_stall <= 1'b0;
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
		cur_seed = sttw_pkg::SEED_RESET;
		rng = 32'd1;
		wx = 0; wy = 0; wz = 0; axis = 0;
		walk_acc = sttw_pkg::FNV_BASIS;
		for (int i = 0; i < CELLS; i++) begin
			order[i] = 10'(i);
			cell_page[i] = '0;
			cell_full[i] = 1'b0;
			cell_rgb[i] = '0;
			cell_energy[i] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random_walks(6, 280);
		write_seed(sttw_pkg::SEED_RESET);
		send_request(sttw_pkg::OP_BUILD, 4'd0);
		test_backpressure();
		wait_drained();
		repeat (50) @(posedge clk);
		if (failures == 0 && pending_visits.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/sttw_pkg.sv
sv/shuffled_torus_table_walker_unit.sv
verif/shuffled_torus_table_walker_unit_test.sv
